[hw/rtl/dipolar_tensor_coefficients_unit_assert.svh]
// Assertion macros for the dipolar tensor coefficient pipeline.
`ifndef DIPOLAR_TENSOR_COEFFICIENTS_UNIT_ASSERT_SVH
`define DIPOLAR_TENSOR_COEFFICIENTS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtc: implication check failed");
`define DTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtc: next-cycle check failed");
`else
`define DTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/dtc_pkg.sv]
package dtc_pkg;

    localparam int CW          = 24;   // coordinate width, Q11.12
    localparam int DW          = CW + 1;
    localparam int SW          = 2 * DW;  // squared distance width
    localparam int QW          = DW;      // distance width
    localparam int LANES       = 5;
    localparam int OW          = 32;
    localparam int UW          = 31;      // Q1.30 direction ratio
    localparam int SQRT_STEPS  = SW / 2;
    localparam int UDIV_STEPS  = UW;
    localparam int MDIV_STEPS  = OW;
    localparam int IDX_W       = 2;

    localparam logic [31:0] KQ = 32'd3337721072;  // 795.7747 in Q10.22

    localparam logic [IDX_W-1:0] REG_METAL_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_METAL_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_METAL_Z = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

endpackage

[hw/rtl/dtc_sqrt.sv]
module dtc_sqrt (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [dtc_pkg::SW-1:0] s_in,
    output logic [dtc_pkg::QW-1:0] q_out
);
    import dtc_pkg::*;

    localparam int RW = SW + 2;

    logic [SW-1:0] op_reg  [SQRT_STEPS];
    logic [RW-1:0] res_reg [SQRT_STEPS];

    // One digit of the bitwise integer root: returns {op, res}.
    function automatic logic [SW+RW-1:0] root_step(logic [SW-1:0] op, logic [RW-1:0] res,
                                                   logic [RW-1:0] bitv);
        logic [RW-1:0] trial;
        trial = res + bitv;
        if ({2'b00, op} >= trial) begin
            root_step = {op - trial[SW-1:0], (res >> 1) + bitv};
        end else begin
            root_step = {op, res >> 1};
        end
    endfunction

    always_ff @(posedge aclk) begin
        logic [SW+RW-1:0] st;
        if (en) begin
            st = root_step(s_in, '0, RW'(1) << (SW - 2));
            op_reg[0]  <= st[SW+RW-1:RW];
            res_reg[0] <= st[RW-1:0];
            for (int j = 1; j < SQRT_STEPS; j++) begin
                st = root_step(op_reg[j-1], res_reg[j-1], RW'(1) << (SW - 2 - 2 * j));
                op_reg[j]  <= st[SW+RW-1:RW];
                res_reg[j] <= st[RW-1:0];
            end
        end
    end

    assign q_out = res_reg[SQRT_STEPS-1][QW-1:0];

endmodule

[hw/rtl/dipolar_tensor_coefficients_unit.sv]
// One atom per cycle unless a result waits at the output. The depth comes from the
// 31-step ratio divide, the 32-step coefficient divide (one quotient bit per stage)
// and the multipliers. The 25-stage distance root runs beside the ratio divide.
// Reset (aresetn low, synchronous) clears the metal centre and all valid bits.
`include "dipolar_tensor_coefficients_unit_assert.svh"
module dipolar_tensor_coefficients_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // atom_x, atom_y, atom_z
    input  logic         s_tlast,   // last_atom
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // coef_xx_minus_zz, coef_xy, coef_xz,
                                    // coef_yy_minus_zz, coef_yz
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,   // last_out
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [dtc_pkg::IDX_W-1:0] cfg_index,
    input  logic [dtc_pkg::CW-1:0]    cfg_data
);
    import dtc_pkg::*;

    localparam int TOTAL = 3 + UDIV_STEPS + 3 + MDIV_STEPS;

    typedef struct packed {
        logic             last;
        logic             zero;
        logic [LANES-1:0] neg;
        logic [SW-1:0]    s;
    } side_t;

    logic en;
    logic [TOTAL-1:0] vld_reg;
    logic [CW-1:0] mx_reg, my_reg, mz_reg;

    // stage 1
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic                 last1_reg;
    // stage 2
    logic [SW-2:0]        x2_reg, y2_reg, z2_reg;
    logic signed [SW-1:0] pxy_reg, pxz_reg, pyz_reg;
    logic                 last2_reg;
    // stage 3
    side_t                side3_reg;
    logic [SW-1:0]        mag3_reg [LANES];
    logic signed [SW:0]   num [LANES];
    logic [SW-1:0]        s_sum;
    // ratio divide
    side_t                side_u_reg [UDIV_STEPS];
    logic [SW:0]          urem_reg [LANES][UDIV_STEPS];
    logic [UW-1:0]        uq_reg   [LANES][UDIV_STEPS];
    logic [QW-1:0]        q_root;
    logic [QW-1:0]        qd_reg [UDIV_STEPS - SQRT_STEPS];
    // products
    side_t                side_p_reg, side_d_reg, side_c_reg;
    logic [62:0]          kp_p_reg [LANES];
    logic [SW-1:0]        pl_reg, ph_reg;
    logic [63:0]          den_d_reg, den_c_reg;
    logic                 dovf_d_reg, dovf_c_reg;
    logic [62:0]          kp_d_reg [LANES];
    logic [LANES-1:0]     big_c_reg;
    logic [63:0]          mrem_c_reg [LANES];
    logic [31:0]          kplo_c_reg [LANES];
    // coefficient divide
    side_t                side_m_reg [MDIV_STEPS];
    logic [63:0]          den_m_reg  [MDIV_STEPS];
    logic                 dovf_m_reg [MDIV_STEPS];
    logic [LANES-1:0]     big_m_reg  [MDIV_STEPS];
    logic [63:0]          mrem_reg [LANES][MDIV_STEPS];
    logic [OW-1:0]        mq_reg   [LANES][MDIV_STEPS];
    logic [31:0]          kplo_reg [LANES][MDIV_STEPS];
    // output
    logic                 m_tvalid_reg;
    logic [159:0]         m_tdata_reg;
    status_t              m_tuser_reg;
    logic                 m_tlast_reg;
    logic [159:0]         coef_next;
    status_t              status_next;
    logic                 extreme_any;

    function automatic logic [SW+1:0] udiv_step(logic [SW:0] t, logic [SW-1:0] s);
        if (t >= {1'b0, s}) begin
            udiv_step = {1'b1, t - {1'b0, s}};
        end else begin
            udiv_step = {1'b0, t};
        end
    endfunction

    function automatic logic [64:0] mdiv_step(logic [64:0] t, logic [63:0] d);
        logic [64:0] r;
        if (t >= {1'b0, d}) begin
            r = t - {1'b0, d};
            mdiv_step = {1'b1, r[63:0]};
        end else begin
            mdiv_step = {1'b0, t[63:0]};
        end
    endfunction

    // hold the whole pipe while a result waits at the output
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mx_reg <= '0;
            my_reg <= '0;
            mz_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_METAL_X: mx_reg <= cfg_data;
                REG_METAL_Y: my_reg <= cfg_data;
                REG_METAL_Z: mz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[TOTAL-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[TOTAL-1];
        end
    end

    // stages 1 to 3: offsets, products, sums
    always_comb begin
        s_sum  = {1'b0, x2_reg} + {1'b0, y2_reg} + {1'b0, z2_reg};
        num[0] = $signed({2'b00, x2_reg}) - $signed({2'b00, z2_reg});
        num[1] = {pxy_reg, 1'b0};
        num[2] = {pxz_reg, 1'b0};
        num[3] = $signed({2'b00, y2_reg}) - $signed({2'b00, z2_reg});
        num[4] = {pyz_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        logic signed [SW-1:0] sq;
        logic signed [SW:0]   ng;
        if (en) begin
            dx_reg    <= $signed({s_tdata[23], s_tdata[23:0]}) - $signed({mx_reg[CW-1], mx_reg});
            dy_reg    <= $signed({s_tdata[47], s_tdata[47:24]}) - $signed({my_reg[CW-1], my_reg});
            dz_reg    <= $signed({s_tdata[71], s_tdata[71:48]}) - $signed({mz_reg[CW-1], mz_reg});
            last1_reg <= s_tlast;

            sq = dx_reg * dx_reg;
            x2_reg <= sq[SW-2:0];
            sq = dy_reg * dy_reg;
            y2_reg <= sq[SW-2:0];
            sq = dz_reg * dz_reg;
            z2_reg <= sq[SW-2:0];
            pxy_reg   <= dx_reg * dy_reg;
            pxz_reg   <= dx_reg * dz_reg;
            pyz_reg   <= dy_reg * dz_reg;
            last2_reg <= last1_reg;

            side3_reg.last <= last2_reg;
            side3_reg.s    <= s_sum;
            side3_reg.zero <= (s_sum == '0);
            for (int l = 0; l < LANES; l++) begin
                side3_reg.neg[l] <= num[l][SW];
                ng = num[l][SW] ? -num[l] : num[l];
                mag3_reg[l] <= ng[SW-1:0];
            end
        end
    end

    dtc_sqrt u_sqrt (
        .aclk  (aclk),
        .en    (en),
        .s_in  (side3_reg.s),
        .q_out (q_root)
    );

    // ratio |N| * 2^30 / s, one quotient bit per stage
    always_ff @(posedge aclk) begin
        logic [SW+1:0] ust;
        if (en) begin
            side_u_reg[0] <= side3_reg;
            for (int l = 0; l < LANES; l++) begin
                ust = udiv_step({1'b0, mag3_reg[l]}, side3_reg.s);
                urem_reg[l][0] <= ust[SW:0];
                uq_reg[l][0]   <= {{(UW-1){1'b0}}, ust[SW+1]};
            end
            for (int k = 1; k < UDIV_STEPS; k++) begin
                side_u_reg[k] <= side_u_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    ust = udiv_step({urem_reg[l][k-1][SW-1:0], 1'b0}, side_u_reg[k-1].s);
                    urem_reg[l][k] <= ust[SW:0];
                    uq_reg[l][k]   <= {uq_reg[l][k-1][UW-2:0], ust[SW+1]};
                end
            end
            // align the root with the end of the ratio divide
            qd_reg[0] <= q_root;
            for (int k = 1; k < UDIV_STEPS - SQRT_STEPS; k++) begin
                qd_reg[k] <= qd_reg[k-1];
            end
        end
    end

    // constant product, s*q in two halves, then the divisor
    always_ff @(posedge aclk) begin
        logic [74:0] den_full;
        if (en) begin
            side_p_reg <= side_u_reg[UDIV_STEPS-1];
            for (int l = 0; l < LANES; l++) begin
                kp_p_reg[l] <= KQ * uq_reg[l][UDIV_STEPS-1];
            end
            pl_reg <= side_u_reg[UDIV_STEPS-1].s[DW-1:0] * qd_reg[UDIV_STEPS-SQRT_STEPS-1];
            ph_reg <= side_u_reg[UDIV_STEPS-1].s[SW-1:DW] * qd_reg[UDIV_STEPS-SQRT_STEPS-1];

            den_full   = {ph_reg, {DW{1'b0}}} + {{DW{1'b0}}, pl_reg};
            side_d_reg <= side_p_reg;
            den_d_reg  <= den_full[63:0];
            dovf_d_reg <= |den_full[74:64];
            for (int l = 0; l < LANES; l++) begin
                kp_d_reg[l] <= kp_p_reg[l];
            end

            side_c_reg <= side_d_reg;
            den_c_reg  <= den_d_reg;
            dovf_c_reg <= dovf_d_reg;
            for (int l = 0; l < LANES; l++) begin
                big_c_reg[l]  <= {33'b0, kp_d_reg[l][62:32]} >= den_d_reg;
                mrem_c_reg[l] <= {33'b0, kp_d_reg[l][62:32]};
                kplo_c_reg[l] <= kp_d_reg[l][31:0];
            end
        end
    end

    // coefficient quotient, one bit per stage
    always_ff @(posedge aclk) begin
        logic [64:0] mst;
        if (en) begin
            side_m_reg[0] <= side_c_reg;
            den_m_reg[0]  <= den_c_reg;
            dovf_m_reg[0] <= dovf_c_reg;
            big_m_reg[0]  <= big_c_reg;
            for (int l = 0; l < LANES; l++) begin
                mst = mdiv_step({mrem_c_reg[l], kplo_c_reg[l][31]}, den_c_reg);
                mrem_reg[l][0] <= mst[63:0];
                mq_reg[l][0]   <= {{(OW-1){1'b0}}, mst[64]};
                kplo_reg[l][0] <= {kplo_c_reg[l][30:0], 1'b0};
            end
            for (int k = 1; k < MDIV_STEPS; k++) begin
                side_m_reg[k] <= side_m_reg[k-1];
                den_m_reg[k]  <= den_m_reg[k-1];
                dovf_m_reg[k] <= dovf_m_reg[k-1];
                big_m_reg[k]  <= big_m_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    mst = mdiv_step({mrem_reg[l][k-1], kplo_reg[l][k-1][31]}, den_m_reg[k-1]);
                    mrem_reg[l][k] <= mst[63:0];
                    mq_reg[l][k]   <= {mq_reg[l][k-1][OW-2:0], mst[64]};
                    kplo_reg[l][k] <= {kplo_reg[l][k-1][30:0], 1'b0};
                end
            end
        end
    end

    // sign, saturation, status
    always_comb begin
        logic [OW-1:0] mq;
        logic          neg;
        logic          sat;
        logic          sat_any;
        logic          dovf;
        sat_any = 1'b0;
        dovf    = dovf_m_reg[MDIV_STEPS-1];
        for (int l = 0; l < LANES; l++) begin
            mq  = mq_reg[l][MDIV_STEPS-1];
            neg = side_m_reg[MDIV_STEPS-1].neg[l];
            sat = !dovf && (big_m_reg[MDIV_STEPS-1][l] ||
                            (neg ? (mq[OW-1] && |mq[OW-2:0]) : mq[OW-1]));
            if (side_m_reg[MDIV_STEPS-1].zero || dovf) begin
                coef_next[OW*l +: OW] = '0;
            end else if (sat) begin
                coef_next[OW*l +: OW] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                coef_next[OW*l +: OW] = neg ? -mq : mq;
            end
            sat_any = sat_any | sat;
        end
        if (side_m_reg[MDIV_STEPS-1].zero) begin
            status_next = STATUS_ZERO;
        end else if (sat_any) begin
            status_next = STATUS_SAT;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= coef_next;
            m_tuser_reg <= status_next;
            m_tlast_reg <= side_m_reg[MDIV_STEPS-1].last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        extreme_any = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            extreme_any = extreme_any || (m_tdata_reg[OW*l +: OW] == 32'h7FFF_FFFF) ||
                          (m_tdata_reg[OW*l +: OW] == 32'h8000_0000);
        end
    end

    `DTC_ASSERT_IMPLIES(a_zero_gives_zero, aclk, aresetn, m_tvalid && (m_tuser == STATUS_ZERO), m_tdata == '0)
    `DTC_ASSERT_IMPLIES(a_sat_has_extreme, aclk, aresetn, m_tvalid && (m_tuser == STATUS_SAT), extreme_any)
    `DTC_ASSERT_IMPLIES(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `DTC_ASSERT_NEXT(a_accept_enters_pipe, aclk, aresetn, s_tvalid && s_tready, vld_reg[0])

endmodule

[bench/tb_dipolar_tensor_coefficients_unit.sv]
module tb_dipolar_tensor_coefficients_unit;
    import dtc_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PIPE_DEPTH = 70;

    typedef struct {
        logic [31:0] coef [5];
        status_t     status;
        logic        last;
    } coef_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;     // atom_x, atom_y, atom_z
    logic         s_tlast = 1'b0;   // last_atom
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;          // coef_xx_minus_zz, coef_xy, coef_xz,
                                    // coef_yy_minus_zz, coef_yz
    logic [1:0]   m_tuser;          // status
    logic         m_tlast;          // last_out
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0]    cfg_data = '0;

    logic [CW-1:0] metal_pos [3];
    coef_row_t     pending_rows [$];
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    dipolar_tensor_coefficients_unit dut (.*);

    always #5 aclk = ~aclk;

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned op, res, bitv;
        op = v;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > op) bitv >>= 2;
        while (bitv != 0) begin
            if (op >= res + bitv) begin
                op -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] scaled_coef(longint num, longint unsigned s,
                                                longint unsigned q, inout bit sat);
        bit neg;
        longint unsigned mag, ratio, rem, m;
        logic [127:0] den;
        neg = num < 0;
        mag = neg ? -num : num;
        ratio = 0;
        rem = mag;
        if (rem >= s) begin
            ratio = 1;
            rem -= s;
        end
        for (int i = 0; i < 30; i++) begin
            rem <<= 1;
            ratio <<= 1;
            if (rem >= s) begin
                rem -= s;
                ratio |= 1;
            end
        end
        den = 128'(s) * 128'(q);
        if (den[127:64] != 0) m = 0;
        else m = (64'(KQ) * ratio) / den[63:0];
        if (!neg) begin
            if (m > 64'h7FFF_FFFF) begin
                sat = 1;
                m = 64'h7FFF_FFFF;
            end
            return m[31:0];
        end
        if (m > 64'h8000_0000) begin
            sat = 1;
            m = 64'h8000_0000;
        end
        return -m[31:0];
    endfunction

    function automatic coef_row_t predict_row(logic [71:0] pos, logic last);
        coef_row_t row;
        longint d [3];
        longint unsigned s, q;
        bit sat;
        sat = 0;
        for (int a = 0; a < 3; a++)
            d[a] = longint'($signed(pos[24*a +: 24])) - longint'($signed(metal_pos[a]));
        s = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
        row.last = last;
        if (s == 0) begin
            for (int j = 0; j < 5; j++) row.coef[j] = '0;
            row.status = STATUS_ZERO;
            return row;
        end
        q = root_floor(s);
        row.coef[0] = scaled_coef(d[0]*d[0] - d[2]*d[2], s, q, sat);
        row.coef[1] = scaled_coef(2*d[0]*d[1], s, q, sat);
        row.coef[2] = scaled_coef(2*d[0]*d[2], s, q, sat);
        row.coef[3] = scaled_coef(d[1]*d[1] - d[2]*d[2], s, q, sat);
        row.coef[4] = scaled_coef(2*d[1]*d[2], s, q, sat);
        row.status = sat ? STATUS_SAT : STATUS_OK;
        return row;
    endfunction

    // Compare each result with the oldest pending row
    always @(posedge aclk) begin
        coef_row_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result %h status %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_rows.pop_front();
                for (int j = 0; j < 5; j++)
                    if (m_tdata[32*j +: 32] !== want.coef[j]) begin
                        mismatches++;
                        $display("%0t: coef %0d expected %h actual %h",
                                 $time, j, want.coef[j], m_tdata[32*j +: 32]);
                    end
                if (m_tuser !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
                end
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_METAL_Z) metal_pos[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_metal(logic [CW-1:0] mx, logic [CW-1:0] my, logic [CW-1:0] mz);
        write_reg(REG_METAL_X, mx);
        write_reg(REG_METAL_Y, my);
        write_reg(REG_METAL_Z, mz);
    endtask

    task automatic send_atom(logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] az,
                             logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pending_rows.push_back(predict_row({az, ay, ax}, last));
    endtask

    // Hold until every request has produced its result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] near_offset(logic [CW-1:0] base);
        int span;
        span = 1 << $urandom_range(17, 2);
        return base + CW'($urandom_range(2*span) - span);
    endfunction

    task automatic test_directed();
        logic [CW-1:0] mn, mx;
        mn = 24'h800000;
        mx = 24'h7FFFFF;
        set_metal('0, '0, '0);
        send_atom('0, '0, '0, 1'b1);                 // zero distance
        send_atom(24'h001000, '0, '0, 1'b0);          // 1 A along x
        send_atom('0, 24'h001000, '0, 1'b0);
        send_atom('0, '0, 24'h001000, 1'b1);
        send_atom(24'h000001, 24'h000001, 24'h000001, 1'b0);  // saturates
        send_atom(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 1'b0);
        send_atom(24'h001800, 24'hFFE800, 24'h000C00, 1'b0);
        send_atom(24'h004000, 24'h003000, 24'hFFE000, 1'b1);
        send_atom(mx, mx, mx, 1'b0);
        send_atom(mn, mn, mn, 1'b1);
        send_atom(mx, mn, mx, 1'b0);
        drain();
        set_metal(mn, mx, mn);
        send_atom(mx, mn, mx, 1'b0);                  // widest span, denominator overflow
        send_atom(mn, mx, mn, 1'b1);                  // zero distance at extremes
        send_atom(mn + 24'd1, mx, mn, 1'b0);
        send_atom(mx, mx, mx, 1'b0);
        send_atom(mn, mn, mn, 1'b1);
        drain();
        write_reg(REG_UNUSED, 24'h123456);            // ignored
        send_atom(mn, mx, mn, 1'b1);
        drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        logic [CW-1:0] m [3];
        logic [CW-1:0] p [3];
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int a = 0; a < 3; a++) m[a] = CW'($urandom);
        set_metal(m[0], m[1], m[2]);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0, 1: for (int a = 0; a < 3; a++) p[a] = CW'($urandom);
                2: p = metal_pos;
                default: for (int a = 0; a < 3; a++) p[a] = near_offset(metal_pos[a]);
            endcase
            send_atom(p[0], p[1], p[2], 1'($urandom_range(1)));
        end
        drain();
    endtask

    initial begin
        metal_pos = '{default: '0};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(0, 0, 170);
        test_random_phase(61, 0, 170);
        test_random_phase(0, 61, 170);
        test_random_phase(12, 12, 170);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
